// ===== hdl/msed_pkg.sv =====
package msed_pkg;

	localparam int TIME_OUT_BITS = 24;

	typedef enum logic [1:0] {
		PH_STATUS = 2'd0,
		PH_ARG1   = 2'd1,
		PH_ARG2   = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		EV_NOTE    = 4'd0,
		EV_TIE     = 4'd1,
		EV_REST    = 4'd2,
		EV_PROGRAM = 4'd3,
		EV_VOLUME  = 4'd4,
		EV_PAN     = 4'd5,
		EV_BEND    = 4'd6,
		EV_END     = 4'd7,
		EV_ERROR   = 4'd8
	} kind_t;

	localparam logic [7:0] ST_NOTE_LAST  = 8'h7c;
	localparam logic [7:0] ST_TIE        = 8'h7d;
	localparam logic [7:0] ST_REST_LO    = 8'h7e;
	localparam logic [7:0] ST_REST_HI    = 8'h7f;
	localparam logic [7:0] ST_PROG_LO    = 8'h80;
	localparam logic [7:0] ST_PROG_HI    = 8'hbf;
	localparam logic [7:0] ST_VOLUME     = 8'hc0;
	localparam logic [7:0] ST_PAN        = 8'hc1;
	localparam logic [7:0] ST_BEND_LO    = 8'hd0;
	localparam logic [7:0] ST_BEND_HI    = 8'he0;
	localparam logic [7:0] ST_TBEND_LO   = 8'he1;
	localparam logic [7:0] ST_TBEND_HI   = 8'hf0;
	localparam logic [7:0] ST_END        = 8'hff;
	localparam logic [7:0] PROG_MASK     = 8'h3f;
	localparam logic [8:0] REST_MASK     = 9'h07f;
	localparam logic [8:0] TBEND_MASK    = 9'h0ff;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] status;
		logic [7:0] argument;
		logic       stopped;
	} msed_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  key;
		logic [7:0]  velocity;
		logic [8:0]  length;
		logic [7:0]  setting;
		logic [11:0] bend;
	} msed_event_t;

	function automatic logic [11:0] bend_of(input logic [7:0] status, input logic [7:0] arg);
		bend_of = {~status[3], status[2:0], arg};
	endfunction

endpackage

// ===== hdl/music_sequence_event_decoder_unit.sv =====
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// input    | in_valid/in_ready  | data_byte
// output   | out_valid/out_ready| event_kind note_key note_velocity length_ticks
//          |                    | setting_value bend_amount event_time
//
// one byte per cycle while the result is not stalled; input register, then result register
// the rate is set by the combinational decode between the input and result registers
// arst_n clears parse state, tick clock, stopped flag and both valid bits
// a stalled result holds the result register; the input register then holds one byte
// after an end or error event every byte is taken and dropped until reset
module music_sequence_event_decoder_unit
	import msed_pkg::*;
#(
	parameter int TIME_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_kind,
	output logic [6:0]  note_key,
	output logic [7:0]  note_velocity,
	output logic [8:0]  length_ticks,
	output logic [7:0]  setting_value,
	output logic [11:0] bend_amount,
	output logic [23:0] event_time
);

	localparam int EXT_BITS = (TIME_BITS > TIME_OUT_BITS) ? TIME_BITS : TIME_OUT_BITS;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 valid_s2;
	msed_event_t          evt_s2;
	logic [23:0]          time_s2;
	msed_state_t          state_q;
	logic [TIME_BITS-1:0] tick_q;

	msed_state_t          state_nxt;
	msed_event_t          evt;
	logic                 emit;
	logic                 fire_s1;
	logic                 load_s2;
	logic [EXT_BITS-1:0]  tick_ext;

	msed_decode u_decode (
		.data_byte (byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.emit      (emit),
		.evt       (evt)
	);

	assign fire_s1  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || fire_s1;
	assign load_s2  = fire_s1 && emit;
	assign tick_ext = EXT_BITS'(tick_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: PH_STATUS, status: '0, argument: '0, stopped: 1'b0};
			tick_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
			if (fire_s1) begin
				state_q <= state_nxt;
				tick_q  <= tick_q + TIME_BITS'(evt.length);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
		if (load_s2) begin
			evt_s2  <= evt;
			time_s2 <= tick_ext[23:0];
		end
	end

	assign out_valid     = valid_s2;
	assign event_kind    = evt_s2.kind;
	assign note_key      = evt_s2.key;
	assign note_velocity = evt_s2.velocity;
	assign length_ticks  = evt_s2.length;
	assign setting_value = evt_s2.setting;
	assign bend_amount   = evt_s2.bend;
	assign event_time    = time_s2;

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.stopped |-> !load_s2)
		else $error("result produced while stopped");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && (evt.kind == EV_END || evt.kind == EV_ERROR) |=> state_q.stopped)
		else $error("end or error event did not stop the decoder");

	a_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(tick_q))
		else $error("tick clock moved without a byte");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |-> !load_s2)
		else $error("result register overwritten while stalled");

endmodule

// ===== hdl/msed_decode.sv =====
module msed_decode
	import msed_pkg::*;
(
	input  logic [7:0]  data_byte,
	input  msed_state_t cur,
	output msed_state_t nxt,
	output logic        emit,
	output msed_event_t evt
);

	logic [7:0] s;
	logic [8:0] len_full;

	assign s        = cur.status;
	assign len_full = {1'b0, data_byte} + 9'd1;

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		evt  = '{kind: EV_NOTE, key: '0, velocity: '0, length: '0, setting: '0, bend: '0};
		if (!cur.stopped) begin
			unique case (cur.phase)
				PH_ARG1: begin
					nxt.phase = PH_STATUS;
					if (s <= ST_NOTE_LAST || (s >= ST_TBEND_LO && s <= ST_TBEND_HI)) begin
						nxt.argument = data_byte;
						nxt.phase    = PH_ARG2;
					end else if (s == ST_TIE) begin
						emit       = 1'b1;
						evt.kind   = EV_TIE;
						evt.length = len_full;
					end else if (s == ST_REST_LO || s == ST_REST_HI) begin
						emit       = 1'b1;
						evt.kind   = EV_REST;
						evt.length = len_full & REST_MASK;
					end else if (s == ST_VOLUME) begin
						emit        = 1'b1;
						evt.kind    = EV_VOLUME;
						evt.setting = data_byte;
					end else if (s == ST_PAN) begin
						emit        = 1'b1;
						evt.kind    = EV_PAN;
						evt.setting = data_byte;
					end else begin
						// instant bend
						emit     = 1'b1;
						evt.kind = EV_BEND;
						evt.bend = bend_of(s, data_byte);
					end
				end
				PH_ARG2: begin
					nxt.phase = PH_STATUS;
					emit      = 1'b1;
					if (s <= ST_NOTE_LAST) begin
						evt.kind     = EV_NOTE;
						evt.key      = s[6:0];
						evt.velocity = cur.argument;
						evt.length   = len_full;
					end else begin
						// timed bend
						evt.kind   = EV_BEND;
						evt.length = len_full & TBEND_MASK;
						evt.bend   = bend_of(s, cur.argument);
					end
				end
				default: begin
					nxt.phase  = PH_STATUS;
					nxt.status = data_byte;
					if (data_byte <= ST_REST_HI || data_byte == ST_VOLUME
							|| data_byte == ST_PAN
							|| (data_byte >= ST_BEND_LO && data_byte <= ST_TBEND_HI)) begin
						nxt.phase = PH_ARG1;
					end else if (data_byte >= ST_PROG_LO && data_byte <= ST_PROG_HI) begin
						emit        = 1'b1;
						evt.kind    = EV_PROGRAM;
						evt.setting = data_byte & PROG_MASK;
					end else if (data_byte == ST_END) begin
						emit        = 1'b1;
						evt.kind    = EV_END;
						nxt.stopped = 1'b1;
					end else begin
						emit        = 1'b1;
						evt.kind    = EV_ERROR;
						nxt.stopped = 1'b1;
					end
				end
			endcase
		end
	end

endmodule
